/* rtl/fsmask_pkg.sv */
`default_nettype none
package fsmask_pkg;

  // Field and register widths
  localparam int PIX_W      = 12;
  localparam int FRM_W      = 13;
  localparam int CEN_W      = 16;
  localparam int BOX_W      = 17;
  localparam int FTH_W      = 16;
  localparam int MODE_W     = 2;
  localparam int ALPHA_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int MAX_SIDE_DEF = 4096;

  // Internal datapath widths (Q16.16 positions and friends)
  localparam int POS_W = 29;   // centre and half extent
  localparam int MAG_W = 30;   // |pixel - centre|
  localparam int MD_W  = 31;   // signed differences
  localparam int Q_W   = 27;   // normalized delta, saturated at 2^26
  localparam int SQ_W  = 54;   // sum of squares
  localparam int RT_W  = 25;   // feather ratio
  localparam int F_W   = 24;   // feather in Q16.16
  localparam int DEN_W = 26;   // ramp denominator
  localparam int N_W   = 34;   // 255 * numerator

  // Pipeline geometry
  localparam int DIV_STAGES  = 27;
  localparam int SQRT_STAGES = 27;
  localparam int ADIV_STAGES = 8;
  localparam int RDIV_STEPS  = 40;
  localparam int RC_DLY      = DIV_STAGES + 3 + SQRT_STAGES;
  localparam int LAT         = 3 + DIV_STAGES + 3 + SQRT_STAGES + 3 + ADIV_STAGES;

  localparam int ONE_Q16     = 65536;
  localparam int DEGEN_LIMIT = 65;
  localparam int DELTA_SAT   = 1 << 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_BOX_WIDTH,
    CFG_BOX_HEIGHT,
    CFG_FEATHER,
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT
  } fsmask_cfg_t;

  typedef enum logic [2:0] {
    ST_PREP1,
    ST_PREP2,
    ST_DIV,
    ST_FIN,
    ST_RUN
  } fsmask_state_t;

endpackage
`default_nettype wire

/* rtl/feathered_shape_mask_core.sv */
`default_nettype none
// Each accepted pixel is carried through the whole pipeline; out_alpha is valid while
// out_strobe is high.
// Throughput: one pixel per clock while busy is low, set by the fully pipelined dividers
// and square root. After reset and after every configuration transfer, busy stays high
// while the shape geometry and feather ratio are rebuilt by a bit-serial divider.
// Reset (rst_n low, synchronous) restores default registers and empties the pipeline;
// the receiver cannot stall, so results leave unconditionally.
module feathered_shape_mask_core #(
  parameter int MAX_SIDE = fsmask_pkg::MAX_SIDE_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [fsmask_pkg::PIX_W-1:0]        in_pixel_x,
  input  wire logic [fsmask_pkg::PIX_W-1:0]        in_pixel_y,
  output logic                                     out_strobe,
  output logic [fsmask_pkg::ALPHA_W-1:0]           out_alpha,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fsmask_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fsmask_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fsmask_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0] mode_r;
  logic [CEN_W-1:0]  cenx_r, ceny_r;
  logic [BOX_W-1:0]  boxw_r, boxh_r;
  logic [FTH_W-1:0]  feather_r;
  logic [FRM_W-1:0]  frmw_r, frmh_r;
  logic              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= '0;
      cenx_r    <= CEN_W'(32768);
      ceny_r    <= CEN_W'(32768);
      boxw_r    <= BOX_W'(32768);
      boxh_r    <= BOX_W'(32768);
      feather_r <= '0;
      frmw_r    <= FRM_W'(1920);
      frmh_r    <= FRM_W'(1080);
    end else if (cfg_wr) begin
      unique case (fsmask_cfg_t'(cfg_index))
        CFG_MODE:         mode_r    <= cfg_data[MODE_W-1:0];
        CFG_CENTER_X:     cenx_r    <= cfg_data[CEN_W-1:0];
        CFG_CENTER_Y:     ceny_r    <= cfg_data[CEN_W-1:0];
        CFG_BOX_WIDTH:    boxw_r    <= cfg_data[BOX_W-1:0];
        CFG_BOX_HEIGHT:   boxh_r    <= cfg_data[BOX_W-1:0];
        CFG_FEATHER:      feather_r <= cfg_data[FTH_W-1:0];
        CFG_FRAME_WIDTH:  frmw_r    <= cfg_data[FRM_W-1:0];
        CFG_FRAME_HEIGHT: frmh_r    <= cfg_data[FRM_W-1:0];
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Geometry sequencer: rebuild derived constants after reset or a config write
  // ---------------------------------------------------------------------------
  fsmask_state_t state_r, state_nxt;
  logic [5:0]    cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PREP1;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_PREP1: state_nxt = ST_PREP2;
      ST_PREP2: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == 6'(RDIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      ST_FIN:  state_nxt = ST_RUN;
      ST_RUN:  state_nxt = ST_RUN;
      default: state_nxt = ST_PREP1;
    endcase
    // A new register value restarts the rebuild
    if (cfg_wr) begin
      state_nxt = ST_PREP1;
    end
  end

  assign busy = (state_r != ST_RUN) || cfg_valid;

  // Frame sizes saturated to MAX_SIDE
  logic [FRM_W-1:0] fws, fhs;
  assign fws = ({4'b0, frmw_r} > 17'(MAX_SIDE)) ? FRM_W'(MAX_SIDE) : frmw_r;
  assign fhs = ({4'b0, frmh_r} > 17'(MAX_SIDE)) ? FRM_W'(MAX_SIDE) : frmh_r;

  logic [POS_W-1:0]   cxp_nxt, cyp_nxt;
  logic [POS_W:0]     hwp_nxt, hhp_nxt;
  assign cxp_nxt = POS_W'(cenx_r) * POS_W'(fws);
  assign cyp_nxt = POS_W'(ceny_r) * POS_W'(fhs);
  assign hwp_nxt = (POS_W+1)'(boxw_r) * (POS_W+1)'(fws);
  assign hhp_nxt = (POS_W+1)'(boxh_r) * (POS_W+1)'(fhs);

  logic [POS_W-1:0]   cx_r, cy_r, hw_r, hh_r;
  logic [F_W-1:0]     f_r;
  logic               fz_r, degen_r;
  logic [POS_W-1:0]   rd_d_r;
  logic [RDIV_STEPS-1:0] rd_q_r;
  logic [POS_W-1:0]   rd_rem_r;
  logic               rz_r;
  logic [DEN_W-1:0]   rden_r, fden_r, one_p_r;
  logic signed [27:0] one_m_r;

  logic [POS_W-1:0] mn_nxt;
  logic [POS_W:0]   rd_t_nxt;
  logic             rd_ge_nxt;
  assign mn_nxt    = (hw_r < hh_r) ? hw_r : hh_r;
  assign rd_t_nxt  = {rd_rem_r, rd_q_r[RDIV_STEPS-1]};
  assign rd_ge_nxt = rd_t_nxt >= {1'b0, rd_d_r};

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP1) begin
      cx_r <= cxp_nxt;
      cy_r <= cyp_nxt;
      hw_r <= hwp_nxt[POS_W:1];
      hh_r <= hhp_nxt[POS_W:1];
      fz_r <= (frmw_r == '0) || (frmh_r == '0);
      f_r  <= {feather_r, 8'b0};
    end
    if (state_r == ST_PREP2) begin
      degen_r  <= !((hw_r > POS_W'(DEGEN_LIMIT)) && (hh_r > POS_W'(DEGEN_LIMIT)));
      rd_d_r   <= (mn_nxt < POS_W'(ONE_Q16)) ? POS_W'(ONE_Q16) : mn_nxt;
      rd_q_r   <= {feather_r, 24'b0};
      rd_rem_r <= '0;
    end
    if (state_r == ST_DIV) begin
      // One restoring step of (f << 16) / max(1.0, min(hw, hh))
      rd_rem_r <= rd_ge_nxt ? POS_W'(rd_t_nxt - {1'b0, rd_d_r}) : POS_W'(rd_t_nxt);
      rd_q_r   <= {rd_q_r[RDIV_STEPS-2:0], rd_ge_nxt};
    end
    if (state_r == ST_FIN) begin
      rz_r    <= (rd_q_r[RT_W-1:0] == '0);
      rden_r  <= {rd_q_r[RT_W-1:0], 1'b0};
      fden_r  <= {1'b0, f_r, 1'b0};
      one_p_r <= DEN_W'(ONE_Q16) + DEN_W'(rd_q_r[RT_W-1:0]);
      one_m_r <= 28'sd65536 - $signed({3'b0, rd_q_r[RT_W-1:0]});
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel pipeline; valid bits travel in one shift line
  // ---------------------------------------------------------------------------
  logic           acc;
  logic [LAT:1]   vld_r;
  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-1:1], acc};
    end
  end

  // Stage 1: capture the pixel
  logic [PIX_W-1:0] px1_r, py1_r;
  always_ff @(posedge clk) begin
    px1_r <= in_pixel_x;
    py1_r <= in_pixel_y;
  end

  // Stage 2: offsets from the centre and signed edge distance
  logic signed [MD_W-1:0] sx_nxt, sy_nxt, mdx_nxt, mdy_nxt;
  logic [MAG_W-1:0]       magx_nxt, magy_nxt;
  logic [MAG_W-1:0]       magx2_r, magy2_r;
  logic signed [MD_W-1:0] md2_r;

  assign sx_nxt   = $signed({3'b0, px1_r, 16'b0}) - $signed({2'b0, cx_r});
  assign sy_nxt   = $signed({3'b0, py1_r, 16'b0}) - $signed({2'b0, cy_r});
  assign magx_nxt = sx_nxt[MD_W-1] ? MAG_W'(-sx_nxt) : MAG_W'(sx_nxt);
  assign magy_nxt = sy_nxt[MD_W-1] ? MAG_W'(-sy_nxt) : MAG_W'(sy_nxt);
  assign mdx_nxt  = $signed({2'b0, hw_r}) - $signed({1'b0, magx_nxt});
  assign mdy_nxt  = $signed({2'b0, hh_r}) - $signed({1'b0, magy_nxt});

  always_ff @(posedge clk) begin
    magx2_r <= magx_nxt;
    magy2_r <= magy_nxt;
    md2_r   <= (mdx_nxt < mdy_nxt) ? mdx_nxt : mdy_nxt;
  end

  // Stage 3: saturation test, divider seed and rectangle coverage
  logic [POS_W-1:0] rx_r [0:DIV_STAGES];
  logic [POS_W-1:0] ry_r [0:DIV_STAGES];
  logic [Q_W-1:0]   lx_r [0:DIV_STAGES];
  logic [Q_W-1:0]   ly_r [0:DIV_STAGES];
  logic [Q_W-1:0]   qx_r [0:DIV_STAGES];
  logic [Q_W-1:0]   qy_r [0:DIV_STAGES];
  logic             satx_r [0:DIV_STAGES];
  logic             saty_r [0:DIV_STAGES];
  logic [DEN_W-1:0] rcn_r [0:RC_DLY];
  logic             rcp_r [0:RC_DLY];

  logic signed [MD_W-1:0] fs_nxt;
  logic [DEN_W-1:0]       rnum_nxt;
  logic                   rramp_nxt;
  assign fs_nxt = $signed({7'b0, f_r});

  always_comb begin
    rnum_nxt  = '0;
    rramp_nxt = 1'b0;
    if (f_r == '0) begin
      rnum_nxt = DEN_W'(md2_r >= 0);
    end else if (md2_r <= -fs_nxt) begin
      rnum_nxt = '0;
    end else if (md2_r >= fs_nxt) begin
      rnum_nxt = DEN_W'(1);
    end else begin
      rnum_nxt  = DEN_W'(md2_r + fs_nxt);
      rramp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    satx_r[0] <= {10'b0, magx2_r} >= {hw_r, 11'b0};
    saty_r[0] <= {10'b0, magy2_r} >= {hh_r, 11'b0};
    rx_r[0]   <= POS_W'(magx2_r[MAG_W-1:11]);
    ry_r[0]   <= POS_W'(magy2_r[MAG_W-1:11]);
    lx_r[0]   <= {magx2_r[10:0], 16'b0};
    ly_r[0]   <= {magy2_r[10:0], 16'b0};
    qx_r[0]   <= '0;
    qy_r[0]   <= '0;
  end

  // Hold the rectangle result alongside the ellipse path
  always_ff @(posedge clk) begin
    rcn_r[0] <= rnum_nxt;
    rcp_r[0] <= rramp_nxt;
    for (int i = 0; i < RC_DLY; i++) begin
      rcn_r[i+1] <= rcn_r[i];
      rcp_r[i+1] <= rcp_r[i];
    end
  end

  // Normalizing dividers: one quotient bit per stage for each axis
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_ndiv
    logic [POS_W:0] tx_nxt, ty_nxt;
    logic           gx_nxt, gy_nxt;
    assign tx_nxt = {rx_r[k], lx_r[k][Q_W-1]};
    assign ty_nxt = {ry_r[k], ly_r[k][Q_W-1]};
    assign gx_nxt = tx_nxt >= {1'b0, hw_r};
    assign gy_nxt = ty_nxt >= {1'b0, hh_r};
    always_ff @(posedge clk) begin
      rx_r[k+1]   <= gx_nxt ? POS_W'(tx_nxt - {1'b0, hw_r}) : POS_W'(tx_nxt);
      ry_r[k+1]   <= gy_nxt ? POS_W'(ty_nxt - {1'b0, hh_r}) : POS_W'(ty_nxt);
      lx_r[k+1]   <= {lx_r[k][Q_W-2:0], 1'b0};
      ly_r[k+1]   <= {ly_r[k][Q_W-2:0], 1'b0};
      qx_r[k+1]   <= {qx_r[k][Q_W-2:0], gx_nxt};
      qy_r[k+1]   <= {qy_r[k][Q_W-2:0], gy_nxt};
      satx_r[k+1] <= satx_r[k];
      saty_r[k+1] <= saty_r[k];
    end
  end

  // Clamp, square, sum
  logic [Q_W-1:0]  dxc_r, dyc_r;
  logic [SQ_W-1:0] sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic [SQ_W-1:0] sv_r [0:SQRT_STAGES];
  logic [SQ_W-1:0] sr_r [0:SQRT_STAGES];

  assign sqx_nxt = dxc_r * dxc_r;
  assign sqy_nxt = dyc_r * dyc_r;

  always_ff @(posedge clk) begin
    dxc_r <= (satx_r[DIV_STAGES] || (qx_r[DIV_STAGES] > Q_W'(DELTA_SAT)))
             ? Q_W'(DELTA_SAT) : qx_r[DIV_STAGES];
    dyc_r <= (saty_r[DIV_STAGES] || (qy_r[DIV_STAGES] > Q_W'(DELTA_SAT)))
             ? Q_W'(DELTA_SAT) : qy_r[DIV_STAGES];
    sqx_r <= sqx_nxt;
    sqy_r <= sqy_nxt;
    sv_r[0] <= sqx_r + sqy_r;
    sr_r[0] <= '0;
  end

  // Integer square root: one result bit per stage
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    localparam int SH = 2 * (SQRT_STAGES - 1 - j);
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << SH;
    logic [SQ_W-1:0] tr_nxt;
    logic            ge_nxt;
    assign tr_nxt = sr_r[j] + BIT;
    assign ge_nxt = sv_r[j] >= tr_nxt;
    always_ff @(posedge clk) begin
      sv_r[j+1] <= ge_nxt ? (sv_r[j] - tr_nxt) : sv_r[j];
      sr_r[j+1] <= ge_nxt ? ((sr_r[j] >> 1) + BIT) : (sr_r[j] >> 1);
    end
  end

  // Decision: ellipse coverage, then pick the shape
  logic [Q_W-1:0]   dist_nxt;
  logic [DEN_W-1:0] enum_nxt, num_d_r;
  logic             eramp_nxt, ramp_d_r;
  assign dist_nxt = sr_r[SQRT_STAGES][Q_W-1:0];

  always_comb begin
    enum_nxt  = '0;
    eramp_nxt = 1'b0;
    if (degen_r) begin
      enum_nxt = '0;
    end else if (f_r == '0) begin
      enum_nxt = DEN_W'(dist_nxt <= Q_W'(ONE_Q16));
    end else if ($signed({1'b0, dist_nxt}) <= one_m_r) begin
      enum_nxt = DEN_W'(1);
    end else if (({1'b0, dist_nxt} >= {2'b0, one_p_r}) || rz_r) begin
      enum_nxt = '0;
    end else begin
      enum_nxt  = DEN_W'({2'b0, one_p_r} - {1'b0, dist_nxt});
      eramp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    num_d_r  <= mode_r[0] ? enum_nxt  : rcn_r[RC_DLY];
    ramp_d_r <= mode_r[0] ? eramp_nxt : rcp_r[RC_DLY];
  end

  // Inversion; a zero frame forces alpha 0
  logic [DEN_W-1:0] den_i_nxt, nsel_r;
  logic             nramp_r;
  assign den_i_nxt = ramp_d_r ? (mode_r[0] ? rden_r : fden_r) : DEN_W'(1);

  always_ff @(posedge clk) begin
    if (fz_r) begin
      nsel_r  <= '0;
      nramp_r <= 1'b0;
    end else begin
      nsel_r  <= mode_r[1] ? (den_i_nxt - num_d_r) : num_d_r;
      nramp_r <= ramp_d_r;
    end
  end

  // Scale by 255 and seed the alpha divider
  logic [DEN_W-1:0]   ar_r [0:ADIV_STAGES];
  logic [ALPHA_W-1:0] al_r [0:ADIV_STAGES];
  logic [ALPHA_W-1:0] aq_r [0:ADIV_STAGES];
  logic               ap_r [0:ADIV_STAGES];
  logic [N_W-1:0]     n255_nxt;
  assign n255_nxt = {nsel_r, 8'b0} - {8'b0, nsel_r};

  always_ff @(posedge clk) begin
    ar_r[0] <= n255_nxt[N_W-1:ALPHA_W];
    al_r[0] <= n255_nxt[ALPHA_W-1:0];
    aq_r[0] <= '0;
    ap_r[0] <= nramp_r;
  end

  for (genvar k = 0; k < ADIV_STAGES; k++) begin : g_adiv
    logic [DEN_W-1:0] den_nxt;
    logic [DEN_W:0]   t_nxt;
    logic             ge_nxt;
    assign den_nxt = ap_r[k] ? (mode_r[0] ? rden_r : fden_r) : DEN_W'(1);
    assign t_nxt   = {ar_r[k], al_r[k][ALPHA_W-1]};
    assign ge_nxt  = t_nxt >= {1'b0, den_nxt};
    always_ff @(posedge clk) begin
      ar_r[k+1] <= ge_nxt ? DEN_W'(t_nxt - {1'b0, den_nxt}) : DEN_W'(t_nxt);
      al_r[k+1] <= {al_r[k][ALPHA_W-2:0], 1'b0};
      aq_r[k+1] <= {aq_r[k][ALPHA_W-2:0], ge_nxt};
      ap_r[k+1] <= ap_r[k];
    end
  end

  assign out_alpha  = aq_r[ADIV_STAGES];
  assign out_strobe = vld_r[LAT];

`ifndef SYNTHESIS
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("config transfer did not restart the geometry rebuild");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= 6'(RDIV_STEPS - 1)))
    else $error("ratio divider ran past its last step");

  a_run_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_RUN) |-> $past(state_r == ST_FIN))
    else $error("ready before the feather ratio was stored");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import fsmask_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PIX_W-1:0] in_pixel_x = '0;
  logic [PIX_W-1:0] in_pixel_y = '0;
  logic out_strobe;
  logic [ALPHA_W-1:0] out_alpha;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  feathered_shape_mask_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_strobe(out_strobe), .out_alpha(out_alpha),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the shape registers, updated on each config transfer.
  logic [MODE_W-1:0] sh_mode;
  logic [CEN_W-1:0] sh_cx, sh_cy;
  logic [BOX_W-1:0] sh_bw, sh_bh;
  logic [FTH_W-1:0] sh_feather;
  logic [FRM_W-1:0] sh_fw, sh_fh;

  logic [ALPHA_W-1:0] alpha_queue[$];
  int errors = 0;
  int items_sent = 0;
  int alphas_seen = 0;
  int config_writes = 0;
  bit no_idle = 1'b0;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned scaled_delta(longint d, longint half);
    longint unsigned mag, q;
    mag = d < 0 ? -d : d;
    q = (mag << 16) / half;
    return q > (64'd1 << 26) ? (64'd1 << 26) : q;
  endfunction

  function automatic logic [ALPHA_W-1:0] mask_alpha(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    longint px, py, fw, fh, cx, cy, hw, hh, f, num, den, m, r, rad, md;
    longint unsigned dx, dy;
    px = longint'(x) << 16;
    py = longint'(y) << 16;
    fw = sh_fw > MAX_SIDE_DEF ? MAX_SIDE_DEF : sh_fw;
    fh = sh_fh > MAX_SIDE_DEF ? MAX_SIDE_DEF : sh_fh;
    num = 0;
    den = 1;
    if (fw == 0 || fh == 0) return '0;
    cx = longint'(sh_cx) * fw;
    cy = longint'(sh_cy) * fh;
    hw = (longint'(sh_bw) * fw) >>> 1;
    hh = (longint'(sh_bh) * fh) >>> 1;
    f = longint'(sh_feather) << 8;
    if (sh_mode[0]) begin
      if (hw > DEGEN_LIMIT && hh > DEGEN_LIMIT) begin
        dx = scaled_delta(px - cx, hw);
        dy = scaled_delta(py - cy, hh);
        rad = root64(dx * dx + dy * dy);
        if (f != 0) begin
          m = hw < hh ? hw : hh;
          if (m < ONE_Q16) m = ONE_Q16;
          r = (f << 16) / m;
          if (rad <= ONE_Q16 - r) num = 1;
          else if (rad >= ONE_Q16 + r || r == 0) num = 0;
          else begin
            num = ONE_Q16 + r - rad;
            den = 2 * r;
          end
        end else begin
          num = rad <= ONE_Q16 ? 1 : 0;
        end
      end
    end else begin
      if (f != 0) begin
        md = px - (cx - hw);
        if (cx + hw - px < md) md = cx + hw - px;
        if (py - (cy - hh) < md) md = py - (cy - hh);
        if (cy + hh - py < md) md = cy + hh - py;
        if (md <= -f) num = 0;
        else if (md >= f) num = 1;
        else begin
          num = md + f;
          den = 2 * f;
        end
      end else begin
        num = (px >= cx - hw && px <= cx + hw && py >= cy - hh && py <= cy + hh) ? 1 : 0;
      end
    end
    if (sh_mode[1]) num = den - num;
    return ALPHA_W'((num * 255) / den);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d (time %0t)", what, got, want, $time);
  endtask

  // Check each strobed alpha against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      alphas_seen++;
      if (alpha_queue.size() == 0) report_mismatch("unexpected alpha", out_alpha, -1);
      else begin
        logic [ALPHA_W-1:0] want;
        want = alpha_queue.pop_front();
        if (out_alpha !== want) report_mismatch("alpha", out_alpha, want);
      end
    end
  end

  // Drop start for a random number of cycles, or not at all.
  task automatic idle_gap();
    if (!no_idle && $urandom_range(99) < 14) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 14);
    end
  endtask

  // Send one pixel; hold start until the edge that accepts it.
  task automatic send_pixel(int x, int y);
    idle_gap();
    start <= 1'b1;
    in_pixel_x <= PIX_W'(x);
    in_pixel_y <= PIX_W'(y);
    @(posedge clk);
    while (busy) @(posedge clk);
    alpha_queue.push_back(mask_alpha(PIX_W'(x), PIX_W'(y)));
    items_sent++;
    @(negedge clk);
  endtask

  // Drain the pipeline, then let the latency pass again.
  task automatic drain();
    start <= 1'b0;
    while (alpha_queue.size() != 0) @(negedge clk);
    repeat (LAT + 5) @(negedge clk);
  endtask

  task automatic write_reg(fsmask_cfg_t idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MODE: sh_mode = MODE_W'(value);
      CFG_CENTER_X: sh_cx = CEN_W'(value);
      CFG_CENTER_Y: sh_cy = CEN_W'(value);
      CFG_BOX_WIDTH: sh_bw = BOX_W'(value);
      CFG_BOX_HEIGHT: sh_bh = BOX_W'(value);
      CFG_FEATHER: sh_feather = FTH_W'(value);
      CFG_FRAME_WIDTH: sh_fw = FRM_W'(value);
      default: sh_fh = FRM_W'(value);
    endcase
    config_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_shape(int md, int cx, int cy, int bw, int bh, int fth, int fw, int fh);
    write_reg(CFG_MODE, md);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_BOX_WIDTH, bw);
    write_reg(CFG_BOX_HEIGHT, bh);
    write_reg(CFG_FEATHER, fth);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
  endtask

  // Pick a pixel at random, near the right box edge or near the centre so the ramps get exercised.
  task automatic send_near_edge();
    int x, y, ex, ey;
    ex = (longint'(sh_cx) * sh_fw + ((longint'(sh_bw) * sh_fw) >>> 1)) >>> 16;
    ey = (longint'(sh_cy) * sh_fh) >>> 16;
    case ($urandom_range(3))
      0: begin x = $urandom_range(4095); y = $urandom_range(4095); end
      1: begin x = ex + $urandom_range(40) - 20; y = ey + $urandom_range(40) - 20; end
      default: begin
        x = ((longint'(sh_cx) * sh_fw) >>> 16) + $urandom_range(600) - 300;
        y = ey + $urandom_range(600) - 300;
      end
    endcase
    send_pixel(x & 12'hfff, y & 12'hfff);
  endtask

  task automatic test_reset_defaults();
    sh_mode = 0; sh_cx = 16'h8000; sh_cy = 16'h8000; sh_bw = 17'h8000;
    sh_bh = 17'h8000; sh_feather = 0; sh_fw = 1920; sh_fh = 1080;
    send_pixel(960, 540);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(480, 270);
    send_pixel(479, 269);
    drain();
  endtask

  task automatic test_directed_shapes();
    // Hard ellipse, inverted feathered rectangle, degenerate ellipse.
    set_shape(1, 16'h8000, 16'h8000, 17'h8000, 17'h8000, 0, 1920, 1080);
    send_pixel(960, 540); send_pixel(1440, 540); send_pixel(1441, 540);
    send_pixel(960, 810);
    drain();
    set_shape(2, 16'hffff, 0, 17'h1ffff, 17'h1ffff, 16'hffff, 4096, 4096);
    send_pixel(0, 0); send_pixel(4095, 0); send_pixel(2048, 2048);
    drain();
    set_shape(3, 16'h4000, 16'hc000, 0, 17'h8000, 16'h0400, 1, 4096);
    send_pixel(0, 0); send_pixel(100, 3000);
    drain();
    // Feather whose ratio truncates to zero, then zero frame size.
    set_shape(1, 16'h8000, 16'h8000, 17'h1ffff, 17'h1ffff, 1, 4096, 4096);
    send_pixel(4095, 2048); send_pixel(2048, 2048);
    drain();
    write_reg(CFG_FRAME_WIDTH, 0);
    send_pixel(10, 10);
    drain();
    write_reg(CFG_FRAME_WIDTH, 8191);
    write_reg(CFG_FRAME_HEIGHT, 0);
    send_pixel(4095, 4095);
    drain();
    // Frame above the saturation point, feathered ellipse.
    set_shape(1, 16'h8000, 16'h8000, 17'h8000, 17'h4000, 16'h4000, 8191, 5000);
    send_pixel(3072, 2048); send_pixel(2048, 2560); send_pixel(3000, 2100);
    drain();
  endtask

  task automatic test_random_shapes();
    int n;
    for (int phase = 0; phase < 24; phase++) begin
      set_shape($urandom_range(3), $urandom_range(65535), $urandom_range(65535),
                $urandom_range(131071) >> ($urandom_range(1) * 2),
                $urandom_range(131071) >> ($urandom_range(1) * 2),
                $urandom_range(1) ? 0 : ($urandom_range(65535) >> $urandom_range(12)),
                $urandom_range(3) == 0 ? $urandom_range(8191) : $urandom_range(4096, 1),
                $urandom_range(3) == 0 ? $urandom_range(8191) : $urandom_range(4096, 1));
      no_idle = (phase == 5);
      n = 55;
      for (int k = 0; k < n; k++) begin
        send_near_edge();
        // Hold off once until all predictions have been met.
        if (phase == 9 && k == 20) begin
          start <= 1'b0;
          while (alpha_queue.size() != 0) @(negedge clk);
        end
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_shapes();
    test_random_shapes();
    $display("Covered %0d pixels over %0d register writes, %0d alphas checked.",
             items_sent, config_writes, alphas_seen);
    if (errors == 0 && alpha_queue.size() == 0) $display("feathered_shape_mask_core: match");
    else $display("feathered_shape_mask_core: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("feathered_shape_mask_core: mismatch");
    $finish;
  end
endmodule

/* files.f */
rtl/fsmask_pkg.sv
rtl/feathered_shape_mask_core.sv
tb/tb.sv
